/* rtl/core/lsoa_pkg.sv */
// Shared types and constants for the three-sector lidar obstacle avoider.
// Used by lsoa_ctrl, lsoa_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package lsoa_pkg;

   localparam int unsigned BEAMS_MAX_DEF = 4096;

   localparam int unsigned DIST_W     = 16;
   localparam int unsigned TURN_W     = 17;
   localparam int unsigned BEAM_CNT_W = 13;
   localparam int unsigned MS_W       = 17;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REASON_W   = 2;

   localparam logic [MS_W-1:0] MS_SAT = 17'h1FFFF;

   localparam int unsigned DIV_STEPS = 2 * DIST_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_FLOOR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_CEILING = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAM_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFETY_GAP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_GAP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_SPEED     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_TURN      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WDOG_PERIOD   = 3'd7;

   localparam logic [DIST_W-1:0]     RST_RANGE_FLOOR   = 16'd100;
   localparam logic [DIST_W-1:0]     RST_RANGE_CEILING = 16'd12000;
   localparam logic [BEAM_CNT_W-1:0] RST_BEAM_COUNT    = 13'd360;
   localparam logic [DIST_W-1:0]     RST_SAFETY_GAP    = 16'd500;
   localparam logic [DIST_W-1:0]     RST_SLOW_GAP      = 16'd1000;
   localparam logic [DIST_W-1:0]     RST_TOP_SPEED     = 16'd200;
   localparam logic [DIST_W-1:0]     RST_TOP_TURN      = 16'd1000;
   localparam logic [DIST_W-1:0]     RST_WDOG_PERIOD   = 16'd500;

   localparam logic [REASON_W-1:0] RSN_SCAN      = 2'd0;
   localparam logic [REASON_W-1:0] RSN_MALFORMED = 2'd1;
   localparam logic [REASON_W-1:0] RSN_WATCHDOG  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_FINISH,
      ST_DIVIDE,
      ST_EMIT
   } lsoa_state_type;

   typedef struct packed {
      logic load_item;
      logic step;
      logic finish;
      logic div_step;
      logic emit;
   } lsoa_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic scan_end;
      logic wdog_fire;
      logic need_div;
      logic div_last;
      logic out_free;
   } lsoa_sts_type;

endpackage

/* rtl/core/lsoa_ctrl.sv */
// Sequencer for the obstacle avoider: accepts a word, steps the datapath,
// runs the speed divide and hands the command to the output register. Uses lsoa_pkg.
`timescale 1ns / 1ps

module lsoa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lsoa_pkg::lsoa_sts_type sts,
   output lsoa_pkg::lsoa_cmd_type cmd
);
   import lsoa_pkg::*;

   lsoa_state_type state_ff;
   lsoa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (sts.is_tick) begin
               state_in = sts.wdog_fire ? ST_EMIT : ST_IDLE;
            end else begin
               state_in = sts.scan_end ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = sts.need_div ? ST_DIVIDE : ST_EMIT;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded while output register busy");

   a_load_then_step: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> cmd.step)
      else $error("accepted word not stepped next cycle");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.step, cmd.finish, cmd.div_step, cmd.emit}))
      else $error("more than one datapath command");

endmodule

/* rtl/core/lsoa_datapath.sv */
// Datapath: config registers, sector minimum tracking, watchdog counters,
// decision logic, radix-2 speed divider and output register. Uses lsoa_pkg.
`timescale 1ns / 1ps

module lsoa_datapath #(
   parameter int unsigned BEAMS_MAX = lsoa_pkg::BEAMS_MAX_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lsoa_pkg::lsoa_cmd_type                  cmd,
   output lsoa_pkg::lsoa_sts_type                  sts,
   input  logic                                    csr_wr_en,
   input  logic        [lsoa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [lsoa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                    req_mode,
   input  logic        [lsoa_pkg::DIST_W-1:0]      req_range_mm,
   input  logic                                    req_is_finite,
   input  logic                                    rsp_stall,
   output logic                                    rsp_valid,
   output logic        [lsoa_pkg::DIST_W-1:0]      rsp_forward_speed,
   output logic signed [lsoa_pkg::TURN_W-1:0]      rsp_turn_rate,
   output logic        [lsoa_pkg::REASON_W-1:0]    rsp_reason
);
   import lsoa_pkg::*;

   localparam int unsigned NW          = $clog2(BEAMS_MAX + 1);
   localparam int unsigned IW          = $clog2(BEAMS_MAX);
   localparam int unsigned THIRD_SHIFT = NW + 2;
   localparam int unsigned PROD_W      = NW + THIRD_SHIFT;
   localparam longint unsigned RECIP_FULL = ((64'd1 << THIRD_SHIFT) / 3) + 1;
   localparam logic [THIRD_SHIFT-1:0] RECIP = THIRD_SHIFT'(RECIP_FULL);
   localparam logic [31:0] BMAX32 = 32'(BEAMS_MAX);

   // configuration
   logic [DIST_W-1:0]     floor_ff, floor_in;
   logic [DIST_W-1:0]     ceiling_ff, ceiling_in;
   logic [BEAM_CNT_W-1:0] beam_count_ff, beam_count_in;
   logic [DIST_W-1:0]     safety_ff, safety_in;
   logic [DIST_W-1:0]     slow_ff, slow_in;
   logic [DIST_W-1:0]     top_speed_ff, top_speed_in;
   logic [DIST_W-1:0]     top_turn_ff, top_turn_in;
   logic [DIST_W-1:0]     wdog_period_ff, wdog_period_in;

   // scan and watchdog state
   logic [IW-1:0]     beam_idx_ff, beam_idx_in;
   logic [NW-1:0]     third_ff, third_in;
   logic [DIST_W-1:0] left_ff, left_in, front_ff, front_in, right_ff, right_in;
   logic              left_seen_ff, left_seen_in;
   logic              front_seen_ff, front_seen_in;
   logic              right_seen_ff, right_seen_in;
   logic [MS_W-1:0]   ms_ff, ms_in;
   logic [DIST_W-1:0] phase_ff, phase_in;

   // latched word
   logic              item_mode_ff, item_finite_ff;
   logic [DIST_W-1:0] item_range_ff;

   // pending result and divider
   logic [DIST_W-1:0]        res_speed_ff, res_speed_in;
   logic signed [TURN_W-1:0] res_turn_ff, res_turn_in;
   logic [REASON_W-1:0]      res_reason_ff, res_reason_in;
   logic                     use_div_ff, use_div_in;
   logic [2*DIST_W-1:0]      num_ff, num_in;
   logic [DIST_W-1:0]        rem_ff, rem_in;
   logic [DIST_W-1:0]        divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]        rsp_speed_ff, rsp_speed_in;
   logic signed [TURN_W-1:0] rsp_turn_ff, rsp_turn_in;
   logic [REASON_W-1:0]      rsp_reason_ff, rsp_reason_in;

   // combinational terms
   logic [31:0]       bc_wide, beam_n_wide;
   logic [NW-1:0]     beam_n;
   logic [PROD_W-1:0] third_prod;
   logic [NW:0]       idx_wide, idx_plus;
   logic              scan_end_w, sample_ok, in_left, in_front;
   logic [DIST_W-1:0] period;
   logic [MS_W-1:0]   ms_inc;
   logic [DIST_W-1:0] phase_inc;
   logic              phase_wrap, wdog_fire_w;
   logic [DIST_W-1:0] dist_l, dist_f, dist_r, turn_mag, gap_diff;
   logic              none_seen, all_blocked, malformed, moving;
   logic              f_above_slow, f_above_safe, f_below_slow, need_div_w;
   logic signed [TURN_W-1:0] turn_pos, turn_scan;
   logic [2*DIST_W-1:0] product;
   logic [DIST_W:0]     rem_sh;
   logic                q_bit;

   assign bc_wide     = 32'(beam_count_ff);
   assign beam_n_wide = (beam_count_ff == '0) ? 32'd1 :
                        ((bc_wide > BMAX32) ? BMAX32 : bc_wide);
   assign beam_n      = beam_n_wide[NW-1:0];
   assign third_prod  = PROD_W'(beam_n) * PROD_W'(RECIP);
   assign third_in    = third_prod[THIRD_SHIFT +: NW];

   assign idx_wide   = (NW + 1)'(beam_idx_ff);
   assign idx_plus   = idx_wide + (NW + 1)'(1);
   assign scan_end_w = idx_plus >= {1'b0, beam_n};
   assign in_left    = idx_wide < {1'b0, third_ff};
   assign in_front   = idx_wide < {third_ff, 1'b0};
   assign sample_ok  = item_finite_ff && (item_range_ff >= floor_ff) &&
                       (item_range_ff <= ceiling_ff);

   assign period      = (wdog_period_ff == '0) ? DIST_W'(1) : wdog_period_ff;
   assign ms_inc      = (ms_ff < MS_SAT) ? (ms_ff + MS_W'(1)) : ms_ff;
   assign phase_inc   = phase_ff + DIST_W'(1);
   assign phase_wrap  = phase_inc >= period;
   assign wdog_fire_w = phase_wrap && (ms_inc > MS_W'(period));

   assign dist_l       = left_seen_ff  ? left_ff  : '0;
   assign dist_f       = front_seen_ff ? front_ff : '0;
   assign dist_r       = right_seen_ff ? right_ff : '0;
   assign none_seen    = !left_seen_ff && !front_seen_ff && !right_seen_ff;
   assign all_blocked  = (dist_f < safety_ff) && (dist_l < safety_ff) &&
                         (dist_r < safety_ff);
   assign malformed    = ceiling_ff <= floor_ff;
   assign f_above_slow = dist_f > slow_ff;
   assign f_above_safe = dist_f > safety_ff;
   assign f_below_slow = dist_f < slow_ff;
   assign moving       = f_above_safe && (top_speed_ff != '0);
   assign turn_mag     = moving ? (top_turn_ff >> 1) : top_turn_ff;
   assign turn_pos     = TURN_W'(turn_mag);
   assign turn_scan    = !f_below_slow ? '0 :
                         ((dist_l > dist_r) ? turn_pos : -turn_pos);
   assign need_div_w   = !malformed && !none_seen && !all_blocked &&
                         !f_above_slow && f_above_safe;
   assign gap_diff     = dist_f - safety_ff;
   assign product      = (2 * DIST_W)'(top_speed_ff) * (2 * DIST_W)'(gap_diff);

   assign rem_sh = {rem_ff, num_ff[2*DIST_W-1]};
   assign q_bit  = rem_sh >= {1'b0, divisor_ff};

   always_comb begin
      floor_in       = floor_ff;
      ceiling_in     = ceiling_ff;
      beam_count_in  = beam_count_ff;
      safety_in      = safety_ff;
      slow_in        = slow_ff;
      top_speed_in   = top_speed_ff;
      top_turn_in    = top_turn_ff;
      wdog_period_in = wdog_period_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RANGE_FLOOR:   floor_in       = csr_wdata;
            CSR_RANGE_CEILING: ceiling_in     = csr_wdata;
            CSR_BEAM_COUNT:    beam_count_in  = csr_wdata[BEAM_CNT_W-1:0];
            CSR_SAFETY_GAP:    safety_in      = csr_wdata;
            CSR_SLOW_GAP:      slow_in        = csr_wdata;
            CSR_TOP_SPEED:     top_speed_in   = csr_wdata;
            CSR_TOP_TURN:      top_turn_in    = csr_wdata;
            CSR_WDOG_PERIOD:   wdog_period_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      beam_idx_in   = beam_idx_ff;
      left_in       = left_ff;
      front_in      = front_ff;
      right_in      = right_ff;
      left_seen_in  = left_seen_ff;
      front_seen_in = front_seen_ff;
      right_seen_in = right_seen_ff;
      ms_in         = ms_ff;
      phase_in      = phase_ff;
      res_speed_in  = res_speed_ff;
      res_turn_in   = res_turn_ff;
      res_reason_in = res_reason_ff;
      use_div_in    = use_div_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_turn_in   = rsp_turn_ff;
      rsp_reason_in = rsp_reason_ff;

      if (cmd.step) begin
         if (item_mode_ff) begin
            ms_in    = ms_inc;
            phase_in = phase_wrap ? '0 : phase_inc;
            if (wdog_fire_w) begin
               res_speed_in  = '0;
               res_turn_in   = '0;
               res_reason_in = RSN_WATCHDOG;
               use_div_in    = 1'b0;
            end
         end else begin
            if (sample_ok) begin
               priority if (in_left) begin
                  if (!left_seen_ff || item_range_ff < left_ff) begin
                     left_in      = item_range_ff;
                     left_seen_in = 1'b1;
                  end
               end else if (in_front) begin
                  if (!front_seen_ff || item_range_ff < front_ff) begin
                     front_in      = item_range_ff;
                     front_seen_in = 1'b1;
                  end
               end else begin
                  if (!right_seen_ff || item_range_ff < right_ff) begin
                     right_in      = item_range_ff;
                     right_seen_in = 1'b1;
                  end
               end
            end
            beam_idx_in = scan_end_w ? '0 : (beam_idx_ff + IW'(1));
         end
      end

      if (cmd.finish) begin
         left_in       = '0;
         front_in      = '0;
         right_in      = '0;
         left_seen_in  = 1'b0;
         front_seen_in = 1'b0;
         right_seen_in = 1'b0;
         ms_in         = '0;
         num_in        = product;
         rem_in        = '0;
         divisor_in    = slow_ff - safety_ff;
         div_cnt_in    = '0;
         use_div_in    = need_div_w;
         res_reason_in = RSN_SCAN;
         res_speed_in  = '0;
         res_turn_in   = '0;
         priority if (malformed) begin
            res_reason_in = RSN_MALFORMED;
         end else if (none_seen) begin
            res_turn_in = '0;
         end else if (all_blocked) begin
            res_turn_in = TURN_W'(top_turn_ff);
         end else begin
            res_speed_in = f_above_slow ? top_speed_ff : '0;
            res_turn_in  = turn_scan;
         end
      end

      if (cmd.div_step) begin
         rem_in     = q_bit ? DIST_W'(rem_sh - {1'b0, divisor_ff}) : rem_sh[DIST_W-1:0];
         num_in     = {num_ff[2*DIST_W-2:0], q_bit};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_speed_in  = use_div_ff ? num_ff[DIST_W-1:0] : res_speed_ff;
         rsp_turn_in   = res_turn_ff;
         rsp_reason_in = res_reason_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff       <= RST_RANGE_FLOOR;
         ceiling_ff     <= RST_RANGE_CEILING;
         beam_count_ff  <= RST_BEAM_COUNT;
         safety_ff      <= RST_SAFETY_GAP;
         slow_ff        <= RST_SLOW_GAP;
         top_speed_ff   <= RST_TOP_SPEED;
         top_turn_ff    <= RST_TOP_TURN;
         wdog_period_ff <= RST_WDOG_PERIOD;
         beam_idx_ff    <= '0;
         left_ff        <= '0;
         front_ff       <= '0;
         right_ff       <= '0;
         left_seen_ff   <= 1'b0;
         front_seen_ff  <= 1'b0;
         right_seen_ff  <= 1'b0;
         ms_ff          <= '0;
         phase_ff       <= '0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         floor_ff       <= floor_in;
         ceiling_ff     <= ceiling_in;
         beam_count_ff  <= beam_count_in;
         safety_ff      <= safety_in;
         slow_ff        <= slow_in;
         top_speed_ff   <= top_speed_in;
         top_turn_ff    <= top_turn_in;
         wdog_period_ff <= wdog_period_in;
         beam_idx_ff    <= beam_idx_in;
         left_ff        <= left_in;
         front_ff       <= front_in;
         right_ff       <= right_in;
         left_seen_ff   <= left_seen_in;
         front_seen_ff  <= front_seen_in;
         right_seen_ff  <= right_seen_in;
         ms_ff          <= ms_in;
         phase_ff       <= phase_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      third_ff      <= third_in;
      res_speed_ff  <= res_speed_in;
      res_turn_ff   <= res_turn_in;
      res_reason_ff <= res_reason_in;
      use_div_ff    <= use_div_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      rsp_speed_ff  <= rsp_speed_in;
      rsp_turn_ff   <= rsp_turn_in;
      rsp_reason_ff <= rsp_reason_in;
      if (cmd.load_item) begin
         item_mode_ff   <= req_mode;
         item_range_ff  <= req_range_mm;
         item_finite_ff <= req_is_finite;
      end
   end

   assign sts.is_tick   = item_mode_ff;
   assign sts.scan_end  = scan_end_w;
   assign sts.wdog_fire = wdog_fire_w;
   assign sts.need_div  = need_div_w;
   assign sts.div_last  = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_forward_speed = rsp_speed_ff;
   assign rsp_turn_rate     = rsp_turn_ff;
   assign rsp_reason        = rsp_reason_ff;

   a_stop_is_still: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_reason_ff != RSN_SCAN) |->
         (rsp_speed_ff == '0 && rsp_turn_ff == '0))
      else $error("stop word carries motion");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (!left_seen_ff && !front_seen_ff && !right_seen_ff &&
                      ms_ff == '0 && beam_idx_ff == '0))
      else $error("scan state not cleared at scan end");

   a_reason_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_reason_ff == RSN_SCAN || rsp_reason_ff == RSN_MALFORMED ||
                        rsp_reason_ff == RSN_WATCHDOG))
      else $error("undefined reason code in output word");

endmodule

/* rtl/core/lidar_sector_obstacle_avoider_unit.sv */
// A tick or mid-scan sample passes the accept and step states; the block then accepts again.
// A watchdog stop passes accept, step and emit; a scan-end word passes accept, step, finish,
// the 32-step radix-2 divider (one quotient bit per cycle) if slow-zone speed needs it, and emit.
// Words are taken one at a time; a held output word stalls the input at the next result.
// Reset: synchronous, active high; config registers take their defaults, scan and watchdog
// state clear to zero, no output word pending.
`timescale 1ns / 1ps

module lidar_sector_obstacle_avoider_unit #(
   parameter int unsigned BEAMS_MAX = lsoa_pkg::BEAMS_MAX_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic        [lsoa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [lsoa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_mode,
   input  logic        [lsoa_pkg::DIST_W-1:0]      req_range_mm,
   input  logic                                    req_is_finite,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic        [lsoa_pkg::DIST_W-1:0]      rsp_forward_speed,
   output logic signed [lsoa_pkg::TURN_W-1:0]      rsp_turn_rate,
   output logic        [lsoa_pkg::REASON_W-1:0]    rsp_reason
);
   import lsoa_pkg::*;

   lsoa_cmd_type cmd;
   lsoa_sts_type sts;

   lsoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lsoa_datapath #(
      .BEAMS_MAX (BEAMS_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_mode),
      .req_range_mm      (req_range_mm),
      .req_is_finite     (req_is_finite),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_forward_speed (rsp_forward_speed),
      .rsp_turn_rate     (rsp_turn_rate),
      .rsp_reason        (rsp_reason)
   );

endmodule
